>>> hdl/tcq_pkg.sv
// Shared constants, codes and controller/datapath types for the ticket queue.
package tcq_pkg;

    localparam int ID_WIDTH             = 31;
    localparam int ACTION_WIDTH         = 2;
    localparam int STATUS_WIDTH         = 3;
    localparam int QUEUE_DEPTH_DEFAULT  = 16;
    localparam int TICKET_WIDTH_DEFAULT = 16;

    // Request action codes
    localparam logic [ACTION_WIDTH-1:0] ACT_ADD_URGENT  = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_ADD_REGULAR = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_SERVE       = 2'd2;

    // Response status codes
    localparam logic [STATUS_WIDTH-1:0] ST_ADDED  = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_SERVED = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CMP,
        S_POP
    } state_t;

    typedef struct packed {
        logic                    load_req;
        logic                    rd_scan;
        logic                    rd_head;
        logic                    idx_next;
        logic                    append;
        logic                    pop;
        logic                    load_result;
        logic [STATUS_WIDTH-1:0] result_code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_add;
        logic is_serve;
        logic cls_empty;
        logic cls_full;
        logic last_idx;
        logic id_match;
        logic any_waiting;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/tcq_req_if.sv
// Request channel: action and client id words with valid/ready.
interface tcq_req_if;
    import tcq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACTION_WIDTH-1:0] action;
    logic [ID_WIDTH-1:0]     client_id;

    modport source (output valid, output action, output client_id, input ready);
    modport sink   (input valid, input action, input client_id, output ready);
endinterface

>>> hdl/tcq_rsp_if.sv
// Response channel: status, ticket and served client words with valid/ready.
interface tcq_rsp_if #(
    parameter int TICKET_WIDTH = tcq_pkg::TICKET_WIDTH_DEFAULT
);
    import tcq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [TICKET_WIDTH-1:0] ticket;
    logic [ID_WIDTH-1:0]     served_id;
    logic                    served_urgent;

    modport source (output valid, output status, output ticket, output served_id,
                    output served_urgent, input ready);
    modport sink   (input valid, input status, input ticket, input served_id,
                    input served_urgent, output ready);
endinterface

>>> hdl/tcq_ctrl.sv
// Request sequencer: accepts a word, scans for duplicates, appends or pops.
module tcq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcq_pkg::dp_stat_t stat,
    output tcq_pkg::ctrl_cmd_t cmd
);
    import tcq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_add)
                begin
                    if (stat.cls_empty)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.append      = 1'b1;
                            cmd.load_result = 1'b1;
                            cmd.result_code = ST_ADDED;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        // first entry read issued here, compared next cycle
                        cmd.rd_scan = 1'b1;
                        state_next  = S_CMP;
                    end
                end
                else if (stat.is_serve)
                begin
                    if (stat.any_waiting)
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_POP;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.load_result = 1'b1;
                        cmd.result_code = ST_EMPTY;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    // unused action code: dropped, no response word
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (stat.id_match)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_result = 1'b1;
                        cmd.result_code = ST_DUP;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.last_idx)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_result = 1'b1;
                        if (stat.cls_full)
                        begin
                            cmd.result_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.append      = 1'b1;
                            cmd.result_code = ST_ADDED;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_next = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.pop         = 1'b1;
                    cmd.load_result = 1'b1;
                    cmd.result_code = ST_SERVED;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/tcq_dp.sv
// Queue storage, pointers, ticket counters and the response register.
module tcq_dp #(
    parameter int QUEUE_DEPTH  = tcq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int TICKET_WIDTH = tcq_pkg::TICKET_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tcq_pkg::ACTION_WIDTH-1:0] req_action,
    input  logic [tcq_pkg::ID_WIDTH-1:0]     req_client_id,
    input  tcq_pkg::ctrl_cmd_t               cmd,
    output tcq_pkg::dp_stat_t                stat,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [tcq_pkg::STATUS_WIDTH-1:0] out_status,
    output logic [TICKET_WIDTH-1:0]          out_ticket,
    output logic [tcq_pkg::ID_WIDTH-1:0]     out_served_id,
    output logic                             out_served_urgent
);
    import tcq_pkg::*;

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = ID_WIDTH + TICKET_WIDTH;

    // circular index add, sum stays below twice the depth
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [ENTRY_W-1:0] urg_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] reg_mem [QUEUE_DEPTH];

    logic [ACTION_WIDTH-1:0] action_reg;
    logic [ID_WIDTH-1:0]     id_reg;
    logic                    cls_urg_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [ENTRY_W-1:0]      urg_rd_reg;
    logic [ENTRY_W-1:0]      reg_rd_reg;

    logic [IDX_W-1:0]        urg_head_reg;
    logic [IDX_W-1:0]        reg_head_reg;
    logic [CNT_W-1:0]        urg_cnt_reg;
    logic [CNT_W-1:0]        reg_cnt_reg;
    logic [TICKET_WIDTH-1:0] urg_tkt_reg;
    logic [TICKET_WIDTH-1:0] reg_tkt_reg;

    logic                    out_valid_reg;
    logic [STATUS_WIDTH-1:0] out_status_reg;
    logic [TICKET_WIDTH-1:0] out_ticket_reg;
    logic [ID_WIDTH-1:0]     out_id_reg;
    logic                    out_urgent_reg;

    logic                    urg_nonempty;
    logic                    reg_nonempty;
    logic                    rd_en;
    logic                    rd_cls_urg;
    logic [IDX_W-1:0]        rd_base;
    logic [CNT_W-1:0]        rd_off;
    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        sel_head;
    logic [CNT_W-1:0]        sel_cnt;
    logic [IDX_W-1:0]        wr_addr;
    logic [TICKET_WIDTH-1:0] tkt_new;
    logic [ENTRY_W-1:0]      rd_entry;
    logic [ID_WIDTH-1:0]     rd_id;
    logic [TICKET_WIDTH-1:0] rd_tkt;

    assign urg_nonempty = (urg_cnt_reg != '0);
    assign reg_nonempty = (reg_cnt_reg != '0);

    // a serve picks its class in the same cycle as the head read
    assign rd_en      = cmd.rd_scan | cmd.rd_head;
    assign rd_cls_urg = cmd.rd_head ? urg_nonempty : cls_urg_reg;
    assign rd_base    = rd_cls_urg ? urg_head_reg : reg_head_reg;
    assign rd_off     = cmd.rd_head ? '0 : idx_reg;
    assign rd_addr    = wrap_add(rd_base, rd_off);

    assign sel_head = cls_urg_reg ? urg_head_reg : reg_head_reg;
    assign sel_cnt  = cls_urg_reg ? urg_cnt_reg : reg_cnt_reg;
    assign wr_addr  = wrap_add(sel_head, sel_cnt);
    assign tkt_new  = (cls_urg_reg ? urg_tkt_reg : reg_tkt_reg) + TICKET_WIDTH'(1);

    assign rd_entry = cls_urg_reg ? urg_rd_reg : reg_rd_reg;
    assign rd_id    = rd_entry[ENTRY_W-1:TICKET_WIDTH];
    assign rd_tkt   = rd_entry[TICKET_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.append && cls_urg_reg)
        begin
            urg_mem[wr_addr] <= {id_reg, tkt_new};
        end
        if (rd_en && rd_cls_urg)
        begin
            urg_rd_reg <= urg_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && !cls_urg_reg)
        begin
            reg_mem[wr_addr] <= {id_reg, tkt_new};
        end
        if (rd_en && !rd_cls_urg)
        begin
            reg_rd_reg <= reg_mem[rd_addr];
        end
    end

    // request word, class and scan index
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            action_reg  <= req_action;
            id_reg      <= req_client_id;
            cls_urg_reg <= (req_action == ACT_ADD_URGENT);
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.rd_head)
            begin
                cls_urg_reg <= urg_nonempty;
            end
            if (cmd.idx_next)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            urg_head_reg <= '0;
            reg_head_reg <= '0;
            urg_cnt_reg  <= '0;
            reg_cnt_reg  <= '0;
            urg_tkt_reg  <= '0;
            reg_tkt_reg  <= '0;
        end
        else
        begin
            if (cmd.append)
            begin
                if (cls_urg_reg)
                begin
                    urg_cnt_reg <= urg_cnt_reg + CNT_W'(1);
                    urg_tkt_reg <= tkt_new;
                end
                else
                begin
                    reg_cnt_reg <= reg_cnt_reg + CNT_W'(1);
                    reg_tkt_reg <= tkt_new;
                end
            end
            if (cmd.pop)
            begin
                if (cls_urg_reg)
                begin
                    urg_head_reg <= wrap_add(urg_head_reg, CNT_W'(1));
                    urg_cnt_reg  <= urg_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    reg_head_reg <= wrap_add(reg_head_reg, CNT_W'(1));
                    reg_cnt_reg  <= reg_cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // response register holds a finished word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_status_reg <= cmd.result_code;
            case (cmd.result_code)
                ST_ADDED:
                begin
                    out_ticket_reg <= tkt_new;
                    out_id_reg     <= '0;
                    out_urgent_reg <= 1'b0;
                end
                ST_SERVED:
                begin
                    out_ticket_reg <= rd_tkt;
                    out_id_reg     <= rd_id;
                    out_urgent_reg <= cls_urg_reg;
                end
                default:
                begin
                    out_ticket_reg <= '0;
                    out_id_reg     <= '0;
                    out_urgent_reg <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.is_add      = (action_reg == ACT_ADD_URGENT) || (action_reg == ACT_ADD_REGULAR);
        stat.is_serve    = (action_reg == ACT_SERVE);
        stat.cls_empty   = (sel_cnt == '0);
        stat.cls_full    = (sel_cnt == CNT_W'(QUEUE_DEPTH));
        stat.last_idx    = ((idx_reg + CNT_W'(1)) == sel_cnt);
        stat.id_match    = (rd_id == id_reg);
        stat.any_waiting = urg_nonempty | reg_nonempty;
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_ticket        = out_ticket_reg;
    assign out_served_id     = out_id_reg;
    assign out_served_urgent = out_urgent_reg;

endmodule

>>> hdl/two_class_priority_ticket_queue_core.sv
// Top level of the two-class strict-priority ticket queue.
// Handles one request word at a time. An add to a class holding waiting
// clients first runs a duplicate check (none when the class is empty): it
// walks that class's queue memory through its single read port, reading
// then comparing one entry at a time. A serve with both queues empty
// answers without a read. The next request is taken as soon as the previous
// one has produced its response word into the output register; a held
// response only stalls once a new response is ready to load.
// No clearing pass after reset: queue memories are only read where occupied.
module two_class_priority_ticket_queue_core #(
    parameter int QUEUE_DEPTH  = tcq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int TICKET_WIDTH = tcq_pkg::TICKET_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    tcq_req_if.sink   req,
    tcq_rsp_if.source rsp
);
    import tcq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    tcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcq_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TICKET_WIDTH (TICKET_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_action        (req.action),
        .req_client_id     (req.client_id),
        .cmd               (cmd),
        .stat              (stat),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_status        (rsp.status),
        .out_ticket        (rsp.ticket),
        .out_served_id     (rsp.served_id),
        .out_served_urgent (rsp.served_urgent)
    );

endmodule
